// ===== rtl/gb5_pkg.sv =====
// Shared types, constants and helpers for the 5x5 Gaussian blur.
// No dependencies; the cell and top module use scoped names, and the bench imports it.
`default_nettype none

package gb5_pkg;

   localparam int KERNEL_SIZE      = 5;
   localparam int RADIUS           = KERNEL_SIZE / 2;
   localparam int WEIGHT_BITS      = 16;
   localparam int WEIGHT_FRAC      = 16;
   localparam int SIZE_BITS        = 11;
   localparam int CSR_ADDR_BITS    = 5;
   localparam int CSR_DATA_BITS    = 32;
   localparam int OUT_DEPTH        = 8;

   localparam int DEF_MAX_SIZE     = 1024;
   localparam int DEF_SAMPLE_BITS  = 16;

   // Register indexes
   localparam logic [2:0] REG_MAP_SIZE   = 3'd0;
   localparam logic [2:0] REG_W_CENTER   = 3'd1;
   localparam logic [2:0] REG_W_AXIS_ONE = 3'd2;
   localparam logic [2:0] REG_W_DIAG_ONE = 3'd3;
   localparam logic [2:0] REG_W_AXIS_TWO = 3'd4;
   localparam logic [2:0] REG_W_KNIGHT   = 3'd5;
   localparam logic [2:0] REG_W_CORNER   = 3'd6;

   // Reset values
   localparam logic [SIZE_BITS-1:0]   RST_MAP_SIZE   = 11'd256;
   localparam logic [WEIGHT_BITS-1:0] RST_W_CENTER   = 16'd23468;
   localparam logic [WEIGHT_BITS-1:0] RST_W_AXIS_ONE = 16'd7619;
   localparam logic [WEIGHT_BITS-1:0] RST_W_DIAG_ONE = 16'd2474;
   localparam logic [WEIGHT_BITS-1:0] RST_W_AXIS_TWO = 16'd261;
   localparam logic [WEIGHT_BITS-1:0] RST_W_KNIGHT   = 16'd85;
   localparam logic [WEIGHT_BITS-1:0] RST_W_CORNER   = 16'd3;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] center;
      logic [WEIGHT_BITS-1:0] axis_one;
      logic [WEIGHT_BITS-1:0] diag_one;
      logic [WEIGHT_BITS-1:0] axis_two;
      logic [WEIGHT_BITS-1:0] knight;
      logic [WEIGHT_BITS-1:0] corner;
   } weights_type;

   // Per-item edge masks: row_ok[k] for window row k, col_ok[c] for window column c
   typedef struct packed {
      logic [KERNEL_SIZE-1:0] row_ok;
      logic [KERNEL_SIZE-1:0] col_ok;
   } tap_mask_type;

   // Weight for absolute offsets a and b from the centre
   function automatic logic [WEIGHT_BITS-1:0] weight_pick(weights_type w, int a, int b);
      int lo;
      int hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (hi == 0)                  return w.center;
      else if (lo == 0 && hi == 1)  return w.axis_one;
      else if (lo == 1 && hi == 1)  return w.diag_one;
      else if (lo == 0 && hi == 2)  return w.axis_two;
      else if (lo == 1 && hi == 2)  return w.knight;
      else                          return w.corner;
   endfunction

   function automatic int abs_dist(int x);
      return (x < 0) ? -x : x;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gb5_line_buffer.sv =====
// Four-row line store: one word per column holding the last four rows.
// Uses gb5_pkg nothing beyond widths handed in; read data registered, with write bypass.
`default_nettype none

module gb5_line_buffer #(
   parameter int MAX_SIZE    = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [$clog2(MAX_SIZE)-1:0]  rd_addr,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_SIZE)-1:0]  wr_addr,
   input  wire logic [4*SAMPLE_BITS-1:0]     wr_data,
   output logic      [4*SAMPLE_BITS-1:0]     rd_data
);

   localparam int WORD_W = 4 * SAMPLE_BITS;

   logic [WORD_W-1:0] mem [MAX_SIZE];
   logic [WORD_W-1:0] rd_q_ff;
   logic [WORD_W-1:0] byp_data_ff;
   logic              byp_ff;
   logic              byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   // take the word being written in the same cycle as the read
   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

`default_nettype wire

// ===== rtl/gb5_cell.sv =====
// One window column cell: holds five taps, weights them and sums the column.
// Depends on gb5_pkg for weight and mask types.
`default_nettype none

module gb5_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int COL_POS     = 0
) (
   input  wire logic                              clock,
   input  wire logic                              shift,
   input  wire logic signed [SAMPLE_BITS-1:0]     col_in  [gb5_pkg::KERNEL_SIZE],
   output logic signed      [SAMPLE_BITS-1:0]     col_out [gb5_pkg::KERNEL_SIZE],
   input  wire gb5_pkg::weights_type              weights,
   input  wire gb5_pkg::tap_mask_type             mask,
   output logic signed      [SAMPLE_BITS+19:0]    sum_out
);

   localparam int KS     = gb5_pkg::KERNEL_SIZE;
   localparam int PROD_W = SAMPLE_BITS + gb5_pkg::WEIGHT_BITS + 1;
   localparam int CELL_W = PROD_W + 3;
   localparam int DJ     = gb5_pkg::abs_dist(gb5_pkg::RADIUS - COL_POS);

   logic signed [SAMPLE_BITS-1:0] tap_ff  [KS];
   logic signed [SAMPLE_BITS-1:0] tap_in  [KS];
   logic signed [PROD_W-1:0]      prod_ff [KS];
   logic signed [PROD_W-1:0]      prod_in [KS];
   logic signed [CELL_W-1:0]      sum_ff;
   logic signed [CELL_W-1:0]      sum_in;

   always_comb begin
      logic [gb5_pkg::WEIGHT_BITS-1:0] wt;
      sum_in = '0;
      for (int k = 0; k < KS; k++) begin
         tap_in[k] = shift ? col_in[k] : tap_ff[k];
         wt = gb5_pkg::weight_pick(weights, gb5_pkg::abs_dist(gb5_pkg::RADIUS - k), DJ);
         if (mask.row_ok[k] && mask.col_ok[COL_POS]) begin
            prod_in[k] = PROD_W'(tap_ff[k]) * PROD_W'($signed({1'b0, wt}));
         end else begin
            prod_in[k] = '0;
         end
         sum_in = sum_in + CELL_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign col_out = tap_ff;
   assign sum_out = sum_ff;

endmodule

`default_nettype wire

// ===== rtl/gb5_out_fifo.sv =====
// Small result queue between the arithmetic pipeline and the result channel.
// Standalone; no package items used.
`default_nettype none

module gb5_out_fifo #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 17
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic                            out_valid,
   output logic [WIDTH-1:0]                out_data,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/gaussian_blur_5x5.sv =====
// Streaming 5x5 Gaussian blur of a square height map, one sample per transfer.
// Throughput: one item per cycle (the line store is read every cycle, written per item);
// hold input only while queued plus in-flight results reach eight.
// Path: a result is registered through stages A to E and the result queue after the item
// that completes its window; that item is 2*size+2 items after the point itself.
// Reset: counters, queue, valid flags and settings return to defaults; line store and data registers are not cleared.
`default_nettype none

module gaussian_blur_5x5 #(
   parameter int MAX_SIZE    = gb5_pkg::DEF_MAX_SIZE,
   parameter int SAMPLE_BITS = gb5_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // input stream
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,  // [SB-1:0] height_in
   input  wire logic                                    req_tuser,  // [0] opcode
   // result stream
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output logic      [((SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,  // [SB-1:0] height_out
   output logic                                         rsp_tlast,  // frame_last
   // register port
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [gb5_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  wire logic [gb5_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic      [gb5_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                         csr_pready
);

   localparam int KS     = gb5_pkg::KERNEL_SIZE;
   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CW     = $clog2(MAX_SIZE);
   localparam int SW     = $clog2(MAX_SIZE + 1);
   localparam int LW     = SW + 2;
   localparam int PROD_W = SAMPLE_BITS + gb5_pkg::WEIGHT_BITS + 1;
   localparam int CELL_W = PROD_W + 3;
   localparam int ACC_W  = CELL_W + 3;
   localparam int Q_W    = ACC_W - gb5_pkg::WEIGHT_FRAC;
   localparam int FW     = SAMPLE_BITS + 1;
   localparam int FCW    = $clog2(gb5_pkg::OUT_DEPTH + 1);
   localparam int IFW    = FCW + 1;
   localparam logic signed [Q_W-1:0] Q_MAX =
      Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(64'sd1 <<< (gb5_pkg::WEIGHT_FRAC - 1));

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   logic [gb5_pkg::SIZE_BITS-1:0] map_size_ff;
   gb5_pkg::weights_type          weights_ff;
   logic                          csr_wr;
   logic [2:0]                    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff         <= gb5_pkg::RST_MAP_SIZE;
         weights_ff.center   <= gb5_pkg::RST_W_CENTER;
         weights_ff.axis_one <= gb5_pkg::RST_W_AXIS_ONE;
         weights_ff.diag_one <= gb5_pkg::RST_W_DIAG_ONE;
         weights_ff.axis_two <= gb5_pkg::RST_W_AXIS_TWO;
         weights_ff.knight   <= gb5_pkg::RST_W_KNIGHT;
         weights_ff.corner   <= gb5_pkg::RST_W_CORNER;
      end else if (csr_wr) begin
         case (csr_idx)
            gb5_pkg::REG_MAP_SIZE:   map_size_ff <= csr_pwdata[gb5_pkg::SIZE_BITS-1:0];
            gb5_pkg::REG_W_CENTER:   weights_ff.center   <= csr_pwdata[15:0];
            gb5_pkg::REG_W_AXIS_ONE: weights_ff.axis_one <= csr_pwdata[15:0];
            gb5_pkg::REG_W_DIAG_ONE: weights_ff.diag_one <= csr_pwdata[15:0];
            gb5_pkg::REG_W_AXIS_TWO: weights_ff.axis_two <= csr_pwdata[15:0];
            gb5_pkg::REG_W_KNIGHT:   weights_ff.knight   <= csr_pwdata[15:0];
            gb5_pkg::REG_W_CORNER:   weights_ff.corner   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         gb5_pkg::REG_MAP_SIZE:   csr_prdata = 32'(map_size_ff);
         gb5_pkg::REG_W_CENTER:   csr_prdata = 32'(weights_ff.center);
         gb5_pkg::REG_W_AXIS_ONE: csr_prdata = 32'(weights_ff.axis_one);
         gb5_pkg::REG_W_DIAG_ONE: csr_prdata = 32'(weights_ff.diag_one);
         gb5_pkg::REG_W_AXIS_TWO: csr_prdata = 32'(weights_ff.axis_two);
         gb5_pkg::REG_W_KNIGHT:   csr_prdata = 32'(weights_ff.knight);
         gb5_pkg::REG_W_CORNER:   csr_prdata = 32'(weights_ff.corner);
         default:                 csr_prdata = '0;
      endcase
   end

   // Effective side length: zero reads as one, anything above the store depth clamps
   logic [SW-1:0] size_eff;
   logic [LW-1:0] lag;

   always_comb begin
      if (map_size_ff == '0) begin
         size_eff = SW'(1);
      end else if (32'(map_size_ff) > 32'(MAX_SIZE)) begin
         size_eff = SW'(MAX_SIZE);
      end else begin
         size_eff = SW'(map_size_ff);
      end
      lag = LW'({size_eff, 1'b0}) + LW'(2);
   end

   // ---------------------------------------------------------------
   // Frame position tracking
   //   col_ff  : column of the incoming item (line store address)
   //   dcnt_ff : items seen until the first result is due
   //   orow/ocol : coordinates of the point the next item completes
   // ---------------------------------------------------------------
   logic                  accept;
   logic [CW-1:0]         col_ff, col_in;
   logic [LW-1:0]         dcnt_ff, dcnt_in;
   logic [CW-1:0]         orow_ff, orow_in;
   logic [CW-1:0]         ocol_ff, ocol_in;
   logic                  active;
   logic                  last_now;
   gb5_pkg::tap_mask_type mask_now;

   assign accept = req_tvalid && req_tready;
   assign active = (dcnt_ff == lag);

   always_comb begin
      logic [SW:0] r_ext;
      logic [SW:0] c_ext;
      logic [SW:0] s_ext;
      r_ext = (SW+1)'(orow_ff);
      c_ext = (SW+1)'(ocol_ff);
      s_ext = (SW+1)'(size_eff);
      // row k sits at vertical offset RADIUS-k; column c at RADIUS-c
      mask_now.row_ok[0] = (r_ext + (SW+1)'(2)) < s_ext;
      mask_now.row_ok[1] = (r_ext + (SW+1)'(1)) < s_ext;
      mask_now.row_ok[2] = 1'b1;
      mask_now.row_ok[3] = (r_ext >= (SW+1)'(1));
      mask_now.row_ok[4] = (r_ext >= (SW+1)'(2));
      mask_now.col_ok[0] = (c_ext + (SW+1)'(2)) < s_ext;
      mask_now.col_ok[1] = (c_ext + (SW+1)'(1)) < s_ext;
      mask_now.col_ok[2] = 1'b1;
      mask_now.col_ok[3] = (c_ext >= (SW+1)'(1));
      mask_now.col_ok[4] = (c_ext >= (SW+1)'(2));

      last_now = active && (SW'(orow_ff) + SW'(1) == size_eff)
                        && (SW'(ocol_ff) + SW'(1) == size_eff);

      col_in  = col_ff;
      dcnt_in = dcnt_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (csr_wr && csr_idx == gb5_pkg::REG_MAP_SIZE) begin
         // new size: abandon the frame
         col_in  = '0;
         dcnt_in = '0;
         orow_in = '0;
         ocol_in = '0;
      end else if (accept) begin
         col_in = (SW'(col_ff) + SW'(1) == size_eff) ? '0 : col_ff + CW'(1);
         if (!active) begin
            dcnt_in = dcnt_ff + LW'(1);
         end else if (last_now) begin
            col_in  = '0;
            dcnt_in = '0;
            orow_in = '0;
            ocol_in = '0;
         end else if (SW'(ocol_ff) + SW'(1) == size_eff) begin
            ocol_in = '0;
            orow_in = orow_ff + CW'(1);
         end else begin
            ocol_in = ocol_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         dcnt_ff <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         col_ff  <= col_in;
         dcnt_ff <= dcnt_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage A: line store read returns, item written back
   // ---------------------------------------------------------------
   logic                          va_ff, oa_ff, la_ff;
   logic signed [SAMPLE_BITS-1:0] xa_ff;
   logic [CW-1:0]                 cola_ff;
   gb5_pkg::tap_mask_type         maska_ff;
   logic [4*SAMPLE_BITS-1:0]      lb_rd;
   logic [4*SAMPLE_BITS-1:0]      lb_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         oa_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         oa_ff <= accept && active;
      end
   end

   // drain ticks enter the window as zero samples
   always_ff @(posedge clock) begin
      xa_ff    <= req_tuser ? '0 : $signed(req_tdata[SAMPLE_BITS-1:0]);
      cola_ff  <= col_ff;
      la_ff    <= last_now;
      maska_ff <= mask_now;
   end

   // push every row down by one: slot 0 takes the new sample
   assign lb_wr = {lb_rd[3*SAMPLE_BITS-1:0], xa_ff};

   gb5_line_buffer #(
      .MAX_SIZE    (MAX_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_line_buffer (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (col_ff),
      .wr_en   (va_ff),
      .wr_addr (cola_ff),
      .wr_data (lb_wr),
      .rd_data (lb_rd)
   );

   // ---------------------------------------------------------------
   // Cell row: column 0 takes the new column, each cell hands its taps on
   // ---------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] col_bus  [KS+1][KS];
   logic signed [CELL_W-1:0]      cell_sum [KS];
   logic                          ob_ff, lb_ff;
   gb5_pkg::tap_mask_type         maskb_ff;

   always_comb begin
      col_bus[0][0] = xa_ff;
      for (int k = 1; k < KS; k++) begin
         col_bus[0][k] = $signed(lb_rd[(k-1)*SAMPLE_BITS +: SAMPLE_BITS]);
      end
   end

   for (genvar c = 0; c < KS; c++) begin : g_cell
      gb5_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .COL_POS     (c)
      ) u_cell (
         .clock   (clock),
         .shift   (va_ff),
         .col_in  (col_bus[c]),
         .col_out (col_bus[c+1]),
         .weights (weights_ff),
         .mask    (maskb_ff),
         .sum_out (cell_sum[c])
      );
   end

   // ---------------------------------------------------------------
   // Stages B..E: products, column sums, total, round and saturate
   // ---------------------------------------------------------------
   logic                    oc_ff, lc_ff, od_ff, ld_ff, oe_ff, le_ff;
   logic signed [ACC_W-1:0] total_ff, total_in;
   logic signed [ACC_W-1:0] rounded;
   logic signed [Q_W-1:0]   q;
   logic [SAMPLE_BITS-1:0]  height;

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_ff <= 1'b0;
         oc_ff <= 1'b0;
         od_ff <= 1'b0;
         oe_ff <= 1'b0;
      end else begin
         ob_ff <= oa_ff;
         oc_ff <= ob_ff;
         od_ff <= oc_ff;
         oe_ff <= od_ff;
      end
   end

   always_comb begin
      total_in = '0;
      for (int c = 0; c < KS; c++) begin
         total_in = total_in + ACC_W'(cell_sum[c]);
      end
   end

   always_ff @(posedge clock) begin
      maskb_ff <= maska_ff;
      lb_ff    <= la_ff;
      lc_ff    <= lb_ff;
      ld_ff    <= lc_ff;
      le_ff    <= ld_ff;
      total_ff <= total_in;
   end

   // round half up, then clamp to the sample range
   always_comb begin
      rounded = total_ff + ROUND_HALF;
      q       = $signed(rounded[ACC_W-1:gb5_pkg::WEIGHT_FRAC]);
      if (q > Q_MAX) begin
         height = Q_MAX[SAMPLE_BITS-1:0];
      end else if (q < Q_MIN) begin
         height = Q_MIN[SAMPLE_BITS-1:0];
      end else begin
         height = q[SAMPLE_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Result queue; hold off input while in-flight results could overfill it
   // ---------------------------------------------------------------
   logic            fifo_valid;
   logic [FW-1:0]   fifo_data;
   logic [FCW-1:0]  fifo_count;
   logic [IFW-1:0]  committed;

   assign committed = IFW'(fifo_count) + IFW'(oa_ff) + IFW'(ob_ff) + IFW'(oc_ff)
                    + IFW'(od_ff) + IFW'(oe_ff);
   assign req_tready = (committed < IFW'(gb5_pkg::OUT_DEPTH));

   gb5_out_fifo #(
      .DEPTH (gb5_pkg::OUT_DEPTH),
      .WIDTH (FW)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (oe_ff),
      .push_data ({le_ff, height}),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (fifo_valid),
      .out_data  (fifo_data),
      .count     (fifo_count)
   );

   assign rsp_tvalid = fifo_valid;
   assign rsp_tdata  = DATA_W'(fifo_data[SAMPLE_BITS-1:0]);
   assign rsp_tlast  = fifo_data[SAMPLE_BITS];

endmodule

`default_nettype wire

// ===== test/gaussian_blur_5x5_test.sv =====
// Self-checking bench for the streaming 5x5 Gaussian blur: random and directed frames
// with bursty input, a stalling receiver and register changes between frames.
// Depends on gb5_pkg and gaussian_blur_5x5 only.
`timescale 1ns / 1ps

module gaussian_blur_5x5_test;
   import gb5_pkg::*;

   localparam bit OP_SAMPLE = 1'b0;
   localparam bit OP_DRAIN  = 1'b1;
   localparam int HIST_LEN  = 4 * DEF_MAX_SIZE + 4 * RADIUS + 8;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE     = 12;

   typedef struct packed {
      logic [15:0] height;
      logic        last;
   } blur_point_type;

   // Scoreboard: shadow registers, sample history, frame counters and the queue
   // of blurred points still owed by the block.
   class blur_scoreboard;
      logic [SIZE_BITS-1:0]   size_reg;
      logic [WEIGHT_BITS-1:0] wt [0:5];
      logic signed [15:0]     hist [0:HIST_LEN-1];
      int unsigned            row, col, left;
      blur_point_type         owed [$];
      int                     errors;

      function new();
         size_reg = RST_MAP_SIZE;
         wt[0] = RST_W_CENTER;   wt[1] = RST_W_AXIS_ONE; wt[2] = RST_W_DIAG_ONE;
         wt[3] = RST_W_AXIS_TWO; wt[4] = RST_W_KNIGHT;   wt[5] = RST_W_CORNER;
         foreach (hist[i]) hist[i] = '0;
         row = 0; col = 0; left = 0; errors = 0;
      endfunction

      function void report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         if (idx == REG_MAP_SIZE) begin
            size_reg = v[SIZE_BITS-1:0];
            row = 0; col = 0; left = 0;   // abandon any open frame
         end else begin
            wt[idx - 1] = v[WEIGHT_BITS-1:0];
         end
      endfunction

      function int unsigned side();
         if (size_reg == 0) return 1;
         if (size_reg > DEF_MAX_SIZE) return DEF_MAX_SIZE;
         return size_reg;
      endfunction

      function logic [15:0] tap_weight(int di, int dj);
         int a, b, lo, hi;
         a = di < 0 ? -di : di;
         b = dj < 0 ? -dj : dj;
         lo = a < b ? a : b;
         hi = a < b ? b : a;
         if (hi == 0) return wt[0];
         if (lo == 0 && hi == 1) return wt[1];
         if (lo == 1 && hi == 1) return wt[2];
         if (lo == 0 && hi == 2) return wt[3];
         if (lo == 1 && hi == 2) return wt[4];
         return wt[5];
      endfunction

      function logic [15:0] blur_at(longint o, int unsigned s);
         longint orow, ocol, rr, cc, acc, q;
         orow = o / s;
         ocol = o % s;
         acc = 0;
         for (int di = -RADIUS; di <= RADIUS; di++)
            for (int dj = -RADIUS; dj <= RADIUS; dj++) begin
               rr = orow + di;
               cc = ocol + dj;
               if (rr >= 0 && cc >= 0 && rr < s && cc < s)
                  acc += longint'(hist[(rr * s + cc) % HIST_LEN])
                         * longint'({1'b0, tap_weight(di, dj)});
            end
         q = (acc + 32768) >>> 16;   // round half up, floor shift
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      function void note_item(bit op, logic [15:0] h);
         int unsigned s;
         longint area, lag, p;
         blur_point_type e;
         s = side();
         area = longint'(s) * s;
         lag = 2 * s + 2;
         p = longint'(row) * s + col;
         if (p == 0 && left == 0) left = 32'(area);
         if (p < area) hist[p % HIST_LEN] = (op == OP_DRAIN) ? 16'sd0 : h;
         col++;
         if (col >= s) begin
            col = 0;
            row++;
         end
         if (p >= lag && left > 0) begin
            left--;
            e.height = blur_at(p - lag, s);
            e.last = (left == 0);
            owed.push_back(e);
            if (e.last) begin
               row = 0;
               col = 0;
            end
         end
      endfunction

      function void check_result(logic [15:0] h, logic last);
         blur_point_type e;
         if (owed.size() == 0) begin
            report($sformatf("unexpected result %h last %b", h, last));
            return;
         end
         e = owed.pop_front();
         if (h !== e.height)
            report($sformatf("height_out %h, expected %h", h, e.height));
         if (last !== e.last)
            report($sformatf("frame_last %b, expected %b", last, e.last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] height_in
   logic        req_tuser = 1'b0; // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] height_out
   logic        rsp_tlast;        // frame_last
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   blur_scoreboard board = new();
   int  idle_cycles = 0;
   int  items_sent = 0;
   int  burst_left = 0;
   int  stall_mode = 0;
   int  stall_timer = 0;

   gaussian_blur_5x5 uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: change stall pattern now and then; keep stretches fully ready.
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_timer <= $urandom_range(20, 120);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // Check every result transfer against the oldest owed point.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast);
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("gaussian_blur_5x5_test failed");
         $finish;
      end
   end

   // Register write: setup cycle, then access cycle; mirror into the scoreboard.
   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_reg(idx, v);
   endtask

   // Hold off until every owed point has arrived and the pipe has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One input transfer; open a random gap when a burst runs out.
   task automatic send_item(bit op, logic [15:0] h);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
         @(negedge clock);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end else begin
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= h;
      do @(posedge clock); while (!req_tready);
      board.note_item(op, h);
      burst_left--;
      items_sent++;
   endtask

   function automatic logic [15:0] pick_height(int style);
      case (style)
         0: return 16'($urandom());
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'h7fff;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'($urandom());
            endcase
         end
      endcase
   endfunction

   // Whole frame: samples then drain ticks, with a little opcode noise.
   task automatic send_frame(int noise_pct);
      int unsigned s;
      int style;
      bit op;
      s = board.side();
      style = $urandom_range(0, 3);
      for (int i = 0; i < s * s + 2 * s + 2; i++) begin
         op = (i < s * s) ? OP_SAMPLE : OP_DRAIN;
         if ($urandom_range(0, 99) < noise_pct) op = ~op;
         send_item(op, pick_height(style));
      end
   endtask

   task automatic set_weights(int style);
      logic [2:0] regs_w [6];
      logic [15:0] dflt [6];
      regs_w = '{REG_W_CENTER, REG_W_AXIS_ONE, REG_W_DIAG_ONE,
                 REG_W_AXIS_TWO, REG_W_KNIGHT, REG_W_CORNER};
      dflt   = '{RST_W_CENTER, RST_W_AXIS_ONE, RST_W_DIAG_ONE,
                 RST_W_AXIS_TWO, RST_W_KNIGHT, RST_W_CORNER};
      for (int k = 0; k < 6; k++)
         case (style)
            0: csr_write(regs_w[k], 32'(dflt[k]));
            1: csr_write(regs_w[k], 32'hffff);
            2: csr_write(regs_w[k], 32'h0);
            default: csr_write(regs_w[k], $urandom_range(0, 65535));
         endcase
   endtask

   initial begin
      int sizes [10] = '{0, 1, 2, 3, 4, 5, 6, 8, 11, 16};
      int s;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: size 3, default weights, extreme samples, drain inside the
      // sample phase and samples inside the drain phase.
      csr_write(REG_MAP_SIZE, 3);
      set_weights(0);
      send_item(OP_SAMPLE, 16'h7fff);
      send_item(OP_SAMPLE, 16'h8000);
      send_item(OP_DRAIN,  16'h1234);
      send_item(OP_SAMPLE, 16'hffff);
      send_item(OP_SAMPLE, 16'h0001);
      send_item(OP_SAMPLE, 16'h0000);
      send_item(OP_SAMPLE, 16'h7fff);
      send_item(OP_SAMPLE, 16'h7fff);
      send_item(OP_SAMPLE, 16'h8000);
      for (int i = 0; i < 8; i++) send_item(i[0] ? OP_SAMPLE : OP_DRAIN, 16'h5555);
      wait_idle();
      // Saturating weights, size zero treated as one
      set_weights(1);
      csr_write(REG_MAP_SIZE, 0);
      send_item(OP_SAMPLE, 16'h7fff);
      for (int i = 0; i < 4; i++) send_item(OP_DRAIN, 16'h0);
      send_item(OP_SAMPLE, 16'h8000);
      for (int i = 0; i < 4; i++) send_item(OP_SAMPLE, 16'h7fff);
      wait_idle();
      // Oversized map: clamps to the maximum; abandon it part way
      csr_write(REG_MAP_SIZE, 32'h7ff);
      for (int i = 0; i < 20; i++) send_item(1'($urandom_range(0, 1)), 16'($urandom()));
      wait_idle();

      // Random phases: new settings, a few frames each, an occasional abort.
      while (items_sent < 1700) begin
         s = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 24)
                                           : sizes[$urandom_range(0, 9)];
         csr_write(REG_MAP_SIZE, s);
         set_weights($urandom_range(0, 5));
         repeat ($urandom_range(1, 3)) begin
            if (items_sent < 1700) send_frame($urandom_range(0, 2) == 0 ? 5 : 0);
         end
         if ($urandom_range(0, 5) == 0) begin
            // broken frame: cut short by a size write
            repeat ($urandom_range(1, 30)) send_item(OP_SAMPLE, 16'($urandom()));
         end
         wait_idle();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("gaussian_blur_5x5_test passed");
      end else begin
         if (board.owed.size() != 0)
            board.report($sformatf("%0d results never arrived", board.owed.size()));
         $display("gaussian_blur_5x5_test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gb5_pkg.sv
rtl/gb5_line_buffer.sv
rtl/gb5_cell.sv
rtl/gb5_out_fifo.sv
rtl/gaussian_blur_5x5.sv
test/gaussian_blur_5x5_test.sv
